FILE: hw/rtl/sfd_pkg.sv
// shared constants, types and state codes of the frame deframer
package sfd_pkg;

	localparam int unsigned BUF_DEPTH = 64;
	localparam int unsigned ADDR_W = $clog2(BUF_DEPTH);
	localparam int unsigned FILL_W = ADDR_W + 1;
	localparam int unsigned LEN_W = ADDR_W + 1;

	localparam logic [7:0] SOF0 = 8'hFF;
	localparam logic [7:0] SOF1 = 8'hFE;
	localparam logic [7:0] EOF0 = 8'hFD;
	localparam logic [7:0] EOF1 = 8'hFC;

	localparam logic [7:0] MIN_LEN = 8'd9;
	localparam logic [7:0] MAX_LEN = 8'(BUF_DEPTH);
	localparam logic [FILL_W-1:0] SCAN_MIN = FILL_W'(5);
	localparam logic [ADDR_W-1:0] OFS_LEN = ADDR_W'(2);
	localparam logic [ADDR_W-1:0] OFS_SEQ = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] OFS_CMD = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] HEAD_BYTES = ADDR_W'(5);
	localparam logic [LEN_W-1:0] SUM_TAIL = LEN_W'(3);
	localparam logic [LEN_W-1:0] OVERHEAD_LAST = LEN_W'(9);

	localparam int unsigned OUT_DATA_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_LEN,
		ST_T0,
		ST_T1,
		ST_SUM,
		ST_SEQ,
		ST_CMD,
		ST_PAY_RD,
		ST_PAY_WR
	} sfd_state_t;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] sequence_number;
		logic [7:0] payload_byte;
		logic [5:0] payload_index;
		logic       last_of_frame;
	} sfd_result_t;

endpackage

FILE: hw/rtl/sfd_ram.sv
// generic simple dual port ram with registered read
module sfd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/sfd_out.sv
// output register stage for result items
module sfd_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  sfd_pkg::sfd_result_t         res,
	output logic                         free,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sfd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                         m_tlast
);

	sfd_pkg::sfd_result_t res_q;
	logic                 valid_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {2'b00, res_q.payload_index, res_q.payload_byte,
		res_q.sequence_number, res_q.command};
	assign m_tlast = res_q.last_of_frame;

endmodule

FILE: hw/rtl/sfd_ctrl.sv
// frame scan sequencer: header, trailer and sum checks over the byte buffer
module sfd_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	output logic                         ram_we,
	output logic [sfd_pkg::ADDR_W-1:0]   ram_waddr,
	output logic                         ram_re,
	output logic [sfd_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic [7:0]                   ram_rdata,
	input  logic                         out_free,
	output logic                         res_load,
	output sfd_pkg::sfd_result_t         res
);

	sfd_pkg::sfd_state_t state_q, state_d;
	logic [sfd_pkg::FILL_W-1:0] fill_q;
	logic [sfd_pkg::ADDR_W-1:0] front_q;
	logic [sfd_pkg::LEN_W-1:0]  len_q;
	logic [sfd_pkg::ADDR_W-1:0] cnt_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 seq_q;
	logic [7:0]                 cmd_q;

	logic                       accept;
	logic                       full;
	logic [sfd_pkg::FILL_W-1:0] fill_in;
	logic                       drop;
	logic                       len_bad;
	logic                       len_short;
	logic                       sum_done;
	logic                       pay_last;
	logic                       consume;
	logic [sfd_pkg::FILL_W-1:0] fill_drop;
	logic [sfd_pkg::FILL_W-1:0] fill_rest;
	logic [sfd_pkg::ADDR_W-1:0] rd_off;

	assign accept = s_tvalid && s_tready;
	assign full = (fill_q == sfd_pkg::FILL_W'(sfd_pkg::BUF_DEPTH));
	assign fill_in = full ? fill_q : fill_q + 1'b1;
	assign len_bad = (ram_rdata < sfd_pkg::MIN_LEN) || (ram_rdata > sfd_pkg::MAX_LEN);
	assign len_short = ({1'b0, fill_q} < ram_rdata);
	assign sum_done = ({1'b0, cnt_q} == len_q - sfd_pkg::SUM_TAIL);
	assign pay_last = ({1'b0, cnt_q} == len_q - sfd_pkg::OVERHEAD_LAST);
	assign consume = (state_q == sfd_pkg::ST_PAY_WR) && out_free && pay_last;
	assign fill_drop = fill_q - 1'b1;
	assign fill_rest = fill_q - len_q;

	// check results of the byte that has just come out of the buffer
	always_comb begin
		drop = 1'b0;
		case (state_q)
			sfd_pkg::ST_RD1: drop = (ram_rdata != sfd_pkg::SOF0);
			sfd_pkg::ST_RD2: drop = (ram_rdata != sfd_pkg::SOF1);
			sfd_pkg::ST_LEN: drop = len_bad;
			sfd_pkg::ST_T0:  drop = (ram_rdata != sfd_pkg::EOF0);
			sfd_pkg::ST_T1:  drop = (ram_rdata != sfd_pkg::EOF1);
			sfd_pkg::ST_SUM: drop = sum_done && (ram_rdata != sum_q);
			default:         drop = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (drop) begin
			state_d = (fill_drop >= sfd_pkg::SCAN_MIN) ? sfd_pkg::ST_RD0 : sfd_pkg::ST_IDLE;
		end else begin
			case (state_q)
				sfd_pkg::ST_IDLE: begin
					if (accept && fill_in >= sfd_pkg::SCAN_MIN) begin
						state_d = sfd_pkg::ST_RD0;
					end
				end
				sfd_pkg::ST_RD0: state_d = sfd_pkg::ST_RD1;
				sfd_pkg::ST_RD1: state_d = sfd_pkg::ST_RD2;
				sfd_pkg::ST_RD2: state_d = sfd_pkg::ST_LEN;
				sfd_pkg::ST_LEN: state_d = len_short ? sfd_pkg::ST_IDLE : sfd_pkg::ST_T0;
				sfd_pkg::ST_T0:  state_d = sfd_pkg::ST_T1;
				sfd_pkg::ST_T1:  state_d = sfd_pkg::ST_SUM;
				sfd_pkg::ST_SUM: begin
					if (sum_done) begin
						state_d = sfd_pkg::ST_SEQ;
					end
				end
				sfd_pkg::ST_SEQ: state_d = sfd_pkg::ST_CMD;
				sfd_pkg::ST_CMD: state_d = sfd_pkg::ST_PAY_RD;
				sfd_pkg::ST_PAY_RD: state_d = sfd_pkg::ST_PAY_WR;
				sfd_pkg::ST_PAY_WR: begin
					if (out_free) begin
						if (!pay_last) begin
							state_d = sfd_pkg::ST_PAY_RD;
						end else if (fill_rest >= sfd_pkg::SCAN_MIN) begin
							state_d = sfd_pkg::ST_RD0;
						end else begin
							state_d = sfd_pkg::ST_IDLE;
						end
					end
				end
				default: state_d = sfd_pkg::ST_IDLE;
			endcase
		end
	end

	// buffer reads and result load
	always_comb begin
		ram_re = 1'b0;
		rd_off = '0;
		res_load = 1'b0;
		s_tready = 1'b0;
		case (state_q)
			sfd_pkg::ST_IDLE: s_tready = 1'b1;
			sfd_pkg::ST_RD0: ram_re = 1'b1;
			sfd_pkg::ST_RD1: begin
				ram_re = 1'b1;
				rd_off = sfd_pkg::ADDR_W'(1);
			end
			sfd_pkg::ST_RD2: begin
				ram_re = 1'b1;
				rd_off = sfd_pkg::OFS_LEN;
			end
			sfd_pkg::ST_LEN: begin
				ram_re = 1'b1;
				rd_off = ram_rdata[sfd_pkg::ADDR_W-1:0] - sfd_pkg::ADDR_W'(2);
			end
			sfd_pkg::ST_T0: begin
				ram_re = 1'b1;
				rd_off = len_q[sfd_pkg::ADDR_W-1:0] - sfd_pkg::ADDR_W'(1);
			end
			sfd_pkg::ST_T1: ram_re = 1'b1;
			sfd_pkg::ST_SUM: begin
				ram_re = 1'b1;
				rd_off = sum_done ? sfd_pkg::OFS_SEQ : cnt_q + 1'b1;
			end
			sfd_pkg::ST_SEQ: begin
				ram_re = 1'b1;
				rd_off = sfd_pkg::OFS_CMD;
			end
			sfd_pkg::ST_PAY_RD: begin
				ram_re = 1'b1;
				rd_off = sfd_pkg::HEAD_BYTES + cnt_q;
			end
			sfd_pkg::ST_PAY_WR: res_load = out_free;
			default: ;
		endcase
	end

	assign ram_raddr = front_q + rd_off;
	assign ram_we = accept;
	assign ram_waddr = front_q + fill_q[sfd_pkg::ADDR_W-1:0];

	assign res.command = cmd_q;
	assign res.sequence_number = seq_q;
	assign res.payload_byte = ram_rdata;
	assign res.payload_index = cnt_q;
	assign res.last_of_frame = pay_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfd_pkg::ST_IDLE;
			fill_q <= '0;
			front_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fill_q <= fill_in;
				if (full) begin
					front_q <= front_q + 1'b1;
				end
			end else if (drop) begin
				fill_q <= fill_drop;
				front_q <= front_q + 1'b1;
			end else if (consume) begin
				fill_q <= fill_rest;
				front_q <= front_q + len_q[sfd_pkg::ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sfd_pkg::ST_LEN: len_q <= ram_rdata[sfd_pkg::LEN_W-1:0];
			sfd_pkg::ST_T1: begin
				cnt_q <= '0;
				sum_q <= '0;
			end
			sfd_pkg::ST_SUM: begin
				if (!sum_done) begin
					sum_q <= sum_q + ram_rdata;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			sfd_pkg::ST_SEQ: seq_q <= ram_rdata;
			sfd_pkg::ST_CMD: begin
				cmd_q <= ram_rdata;
				cnt_q <= '0;
			end
			sfd_pkg::ST_PAY_WR: begin
				if (out_free && !pay_last) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sfd_pkg::FILL_W'(sfd_pkg::BUF_DEPTH))
		else $error("buffer fill count above depth");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfd_pkg::ST_SUM |-> {1'b0, cnt_q} <= len_q - sfd_pkg::SUM_TAIL)
		else $error("sum walk ran past the checksum byte");

	a_pay_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && !pay_last |=> state_q == sfd_pkg::ST_PAY_RD)
		else $error("payload walk did not continue after a non-final item");

	a_frame_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfd_pkg::ST_PAY_WR |-> fill_q >= len_q)
		else $error("emitting a frame longer than the buffered bytes");

endmodule

FILE: hw/rtl/sum_checked_frame_deframer.sv
// top level of the sum-checked frame deframer
// input items are taken only in the idle state; the scan then walks the buffer ram
// through header states RD0, RD1, RD2 and LEN, trailer states T0 and T1, the sum
// state SUM, then SEQ and CMD, and PAY_RD and PAY_WR for each payload byte;
// s_tready stays low while a frame is scanned, and longer when the output stalls;
// a failed check drops the front byte and rescans, or waits in idle for more bytes
// arst_n clears fill count, front pointer and output valid; buffer content is not cleared
module sum_checked_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] command, [15:8] sequence_number,
	                              // [23:16] payload_byte, [29:24] payload_index
	output logic        m_tlast   // last_of_frame
);

	logic                       ram_we;
	logic [sfd_pkg::ADDR_W-1:0] ram_waddr;
	logic                       ram_re;
	logic [sfd_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                 ram_rdata;
	logic                       out_free;
	logic                       res_load;
	sfd_pkg::sfd_result_t       res;

	sfd_ram #(
		.WIDTH(8),
		.DEPTH(sfd_pkg::BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res)
	);

	sfd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_load),
		.res     (res),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
